// File: design/lnmr_pkg.sv
// ----------------------------------------------------------------------------
// lnmr_pkg
// Shared types and constants for the latest-N message ring.
// ----------------------------------------------------------------------------
package lnmr_pkg;

    localparam int MAX_DEPTH_DEF   = 16;
    localparam int ENTRY_WIDTH_DEF = 64;

    localparam int DEPTH_W = 5;
    localparam int GEN_W   = 32;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = $clog2(GEN_W);

    localparam logic CMD_PUBLISH = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the input item
        logic clamp;     // clamp a lagging reader generation
        logic back;      // step back a reader that is already current
        logic mod_load;  // start the remainder unit
        logic mod_step;  // one remainder bit
        logic mem_wr;    // publish into the ring
        logic mem_rd;    // read the ring, finish the reader generation
        logic load_out;  // move the result into the output register
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_read;
        logic is_empty;
        logic mod_last;
        logic out_free;
    } t_ctl_status;

endpackage

// File: design/lnmr_ctrl.sv
// ----------------------------------------------------------------------------
// lnmr_ctrl
// Sequencer for one item: capture, generation fix-up, remainder, ring access,
// result hand-off.
// ----------------------------------------------------------------------------
module lnmr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lnmr_pkg::t_ctl_status i_stat,
    output lnmr_pkg::t_ctl_cmd    o_cmd
);
    import lnmr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_BACK  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_MOD   = 3'd4;
    localparam logic [2:0] ST_MEM   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                // a pending depth write goes first
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                // empty reads go straight to the result
                if (i_stat.is_empty) begin
                    n_state = ST_FIN;
                end else if (i_stat.is_read) begin
                    o_cmd.clamp = 1'b1;
                    n_state     = ST_BACK;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_BACK: begin
                o_cmd.back = 1'b1;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.mod_load = 1'b1;
                n_state        = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = ST_MEM;
                end
            end
            ST_MEM: begin
                o_cmd.mem_wr = !i_stat.is_read;
                o_cmd.mem_rd = i_stat.is_read;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cfg_ready = i_rst_n && (r_state == ST_IDLE);
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE) && !i_cfg_valid;

endmodule

// File: design/lnmr_dp.sv
// ----------------------------------------------------------------------------
// lnmr_dp
// Datapath: depth register, publish counter, generation arithmetic,
// bit-serial remainder unit, ring memory and output register.
// ----------------------------------------------------------------------------
module lnmr_dp #(
    parameter int MAX_DEPTH   = lnmr_pkg::MAX_DEPTH_DEF,
    parameter int ENTRY_WIDTH = lnmr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [lnmr_pkg::DEPTH_W-1:0] i_cfg_data,
    input  logic                         i_command,
    input  logic [lnmr_pkg::DATA_W-1:0]  i_payload,
    input  logic [lnmr_pkg::GEN_W-1:0]   i_reader_generation,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_status,
    output logic [lnmr_pkg::DATA_W-1:0]  o_read_data,
    output logic [lnmr_pkg::GEN_W-1:0]   o_next_generation,
    input  lnmr_pkg::t_ctl_cmd           i_cmd,
    output lnmr_pkg::t_ctl_status        o_stat
);
    import lnmr_pkg::*;

    localparam int DEPTH_MAXV = (1 << DEPTH_W) - 1;
    localparam int MEM_DEPTH  = (MAX_DEPTH < DEPTH_MAXV) ? MAX_DEPTH : DEPTH_MAXV;
    localparam int SLOT_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [DEPTH_W:0] DEPTH_CAP = (DEPTH_W + 1)'(MEM_DEPTH);

    logic [DEPTH_W-1:0]     r_depth;
    logic [GEN_W-1:0]       r_count;
    logic                   r_has_data;
    logic                   r_cmd;
    logic                   r_empty;
    logic [ENTRY_WIDTH-1:0] r_payload;
    logic [GEN_W-1:0]       r_gen;
    logic [GEN_W-1:0]       r_div;
    logic [DEPTH_W-1:0]     r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic [ENTRY_WIDTH-1:0] r_rd;
    logic                   r_out_valid;
    logic                   r_status;
    logic [DATA_W-1:0]      r_data;
    logic [GEN_W-1:0]       r_next_gen;

    logic [ENTRY_WIDTH-1:0] mem [MEM_DEPTH];

    logic [GEN_W-1:0]   depth_ext;
    logic [GEN_W-1:0]   gen_plus_d;
    logic [DEPTH_W:0]   rem_shift;
    logic [DEPTH_W:0]   depth_w1;
    logic [SLOT_W-1:0]  slot;

    assign depth_ext  = GEN_W'(r_depth);
    assign gen_plus_d = r_gen + depth_ext;
    assign depth_w1   = {1'b0, r_depth};
    assign rem_shift  = {r_rem, r_div[GEN_W-1]};
    assign slot       = r_rem[SLOT_W-1:0];

    // Depth register: grow only, never past the ring, never after a publish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_W'(1);
        end else if (i_cfg_valid && !r_has_data && (i_cfg_data > r_depth)
                     && ({1'b0, i_cfg_data} <= DEPTH_CAP)) begin
            r_depth <= i_cfg_data;
        end
    end

    // Publish counter and first-publish flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_has_data <= 1'b0;
        end else if (i_cmd.mem_wr) begin
            r_count    <= r_count + GEN_W'(1);
            r_has_data <= 1'b1;
        end
    end

    // Item capture and generation fix-up
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd     <= i_command;
            r_empty   <= (i_command == CMD_READ) && !r_has_data;
            r_payload <= i_payload[ENTRY_WIDTH-1:0];
            r_gen     <= i_reader_generation;
        end else if (i_cmd.clamp) begin
            if (r_count > gen_plus_d) begin
                r_gen <= r_count - depth_ext;
            end
        end else if (i_cmd.back) begin
            if ((r_count == r_gen) && (r_gen != '0)) begin
                r_gen <= r_gen - GEN_W'(1);
            end
        end else if (i_cmd.mem_rd) begin
            if (r_depth == DEPTH_W'(1)) begin
                r_gen <= r_count;
            end else if (r_gen < r_count) begin
                r_gen <= r_gen + GEN_W'(1);
            end
        end
    end

    // Restoring remainder, one dividend bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_load) begin
            r_div <= (r_cmd == CMD_READ) ? r_gen : r_count;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_div <= {r_div[GEN_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
            if (rem_shift >= depth_w1) begin
                r_rem <= DEPTH_W'(rem_shift - depth_w1);
            end else begin
                r_rem <= rem_shift[DEPTH_W-1:0];
            end
        end
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[slot] <= r_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd <= mem[slot];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= r_empty ? STATUS_EMPTY : STATUS_OK;
            if (r_cmd == CMD_PUBLISH) begin
                r_data     <= '0;
                r_next_gen <= r_count;
            end else if (r_empty) begin
                r_data     <= '0;
                r_next_gen <= r_gen;
            end else begin
                r_data     <= DATA_W'(r_rd);
                r_next_gen <= r_gen;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_read_data       = r_data;
    assign o_next_generation = r_next_gen;

    assign o_stat.is_read  = (r_cmd == CMD_READ);
    assign o_stat.is_empty = r_empty;
    assign o_stat.mod_last = (r_cnt == CNT_W'(GEN_W - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

// File: design/latest_n_message_ring_unit.sv
// ----------------------------------------------------------------------------
// latest_n_message_ring_unit
// Overwriting message ring with a wrapping publish generation and per-reader
// positions.
// ----------------------------------------------------------------------------
// A publish (command 0) stores the payload at slot publish_count mod depth and
// returns the incremented publish_count. A read (command 1) takes the
// subscriber's generation, pulls it up to publish_count - depth if it lags by
// more than the ring, steps it back one if it is already current (so the
// newest entry is read again), reads that slot and returns the data with the
// generation advanced by one while still behind. A read before any publish
// returns status 1, zero data and the generation unchanged. The depth is set
// through the cfg channel; writes that shrink it, exceed the ring or arrive
// after the first publish are dropped. The cfg channel is ready only while no
// item is being processed, and a pending cfg write goes ahead of a waiting
// input item. One item at a time is processed. A bit-serial remainder unit,
// which spends one cycle on each of the 32 generation bits, finds the slot
// for a depth that need not be a power of two; an empty read skips it. The
// result sits in an output register, so the next item is taken while the
// last one waits to be read. The ring memory has no reset; entries read
// before any publish wrote them hold whatever the array powers up with.
// ----------------------------------------------------------------------------
module latest_n_message_ring_unit #(
    parameter int MAX_DEPTH   = lnmr_pkg::MAX_DEPTH_DEF,
    parameter int ENTRY_WIDTH = lnmr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel (queue depth)
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lnmr_pkg::DEPTH_W-1:0] i_cfg_data,
    // input item channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [lnmr_pkg::DATA_W-1:0]  i_payload,
    input  logic [lnmr_pkg::GEN_W-1:0]   i_reader_generation,
    // result item channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_status,
    output logic [lnmr_pkg::DATA_W-1:0]  o_read_data,
    output logic [lnmr_pkg::GEN_W-1:0]   o_next_generation
);
    import lnmr_pkg::*;

    t_ctl_cmd    ctl_cmd;
    t_ctl_status ctl_stat;
    logic        cfg_we;

    // The depth register takes a write only between items.
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    // Sequencer: walks each item through capture, fix-up, remainder, ring
    // access and hand-off to the output register.
    lnmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_stat      (ctl_stat),
        .o_cmd       (ctl_cmd)
    );

    // Datapath: all state but the sequencer's, the remainder unit, the ring and the result.
    lnmr_dp #(
        .MAX_DEPTH   (MAX_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_command           (i_command),
        .i_payload           (i_payload),
        .i_reader_generation (i_reader_generation),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_read_data         (o_read_data),
        .o_next_generation   (o_next_generation),
        .i_cmd               (ctl_cmd),
        .o_stat              (ctl_stat)
    );

    // An accepted item keeps the input closed for at least the next cycle.
    a_one_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("input accepted while an item is in flight");

    // The result register is loaded only when it is empty or being drained.
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.load_out |-> (!o_out_valid || i_out_ready)
    ) else $error("result overwritten before it was taken");

    // An empty-ring status always comes with zero data.
    a_empty_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_EMPTY)) |-> (o_read_data == '0)
    ) else $error("empty status with nonzero data");

    // A ring write is followed by a result load in the next cycle or later,
    // never in the same cycle as the capture of a new item.
    a_write_then_fin: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.mem_wr |=> !o_in_ready
    ) else $error("input opened before the publish result was loaded");

endmodule
